/* rtl/cbs_pkg.sv */
// Shared constants, types and helpers for the channel breakout signal block.
// Used by cbs_cell, cbs_chain, channel_breakout_signal and cbs_checker.
`default_nettype none
package cbs_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int HELD_W     = $clog2(WINDOW_MAX + 2);
  localparam int SCAN_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic [1:0] CFG_SYMBOL_ID = 2'd0;
  localparam logic [1:0] CFG_LOOKBACK  = 2'd1;
  localparam logic [1:0] CFG_ENTRY_QTY = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_BUY  = 2'd1;
  localparam logic [1:0] ACT_SELL = 2'd2;

  localparam logic [6:0]  LOOKBACK_RST  = 7'd20;
  localparam logic [15:0] ENTRY_QTY_RST = 16'd100;

  typedef struct packed {
    logic shift;   // insert a new word at the head, push the rest down
    logic rotate;  // move every word one place toward the head, head wraps to tail
  } cell_ctl_t;

  // Clamp the configured lookback into 1..WINDOW_MAX.
  function automatic logic [LEN_W-1:0] eff_len(input logic [6:0] lb);
    logic [LEN_W-1:0] res;
    if (lb == 7'd0) begin
      res = LEN_W'(1);
    end else if (32'(lb) > 32'(WINDOW_MAX)) begin
      res = LEN_W'(WINDOW_MAX);
    end else begin
      res = LEN_W'(lb);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/channel_breakout_signal.sv */
// Donchian channel breakout signal: top level with control FSM and channel scan.
// Depends on cbs_pkg and cbs_chain.
//
//   channel | handshake          | words
//   --------+--------------------+--------------------------------------------
//   in_     | in_valid/in_ready  | bar symbol, high, low, close, position
//   out_    | out_valid/out_ready| action, qty, channel high/low, ready, total
//   cfg_    | cfg_we             | index cfg_addr, data cfg_wdata
//
// A bar of the selected symbol that can form a channel passes through ST_SCAN,
// where the history row rotates once past a single max/min accumulator at its
// head. Any other bar skips ST_SCAN. One bar is in work at a time; a finished
// word waits in the output register while the next bar is accepted.
// Reset clears control state and the trade counter; no clearing pass exists.
// A stalled output holds the finish step until the output register frees.
`default_nettype none
module channel_breakout_signal (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_bar_symbol,
  input  wire logic [31:0] in_bar_high,
  input  wire logic [31:0] in_bar_low,
  input  wire logic [31:0] in_bar_close,
  input  wire logic signed [23:0] in_position_qty,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_action,
  output logic [22:0]      out_order_qty,
  output logic [31:0]      out_channel_high,
  output logic [31:0]      out_channel_low,
  output logic             out_history_ready,
  output logic [31:0]      out_trade_total
);

  localparam int LEN_W  = cbs_pkg::LEN_W;
  localparam int HELD_W = cbs_pkg::HELD_W;
  localparam int SCAN_W = cbs_pkg::SCAN_W;
  localparam logic [HELD_W-1:0] HELD_MAX  = HELD_W'(cbs_pkg::WINDOW_MAX + 1);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(cbs_pkg::WINDOW_MAX - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t state_r;

  logic [15:0] symbol_id_r;
  logic [6:0]  lookback_r;
  logic [15:0] entry_qty_r;

  logic [31:0] bar_high_r, bar_low_r, bar_close_r;
  logic [23:0] pos_r;
  logic        match_r, hist_ok_r;
  logic [HELD_W-1:0] held_r;
  logic [SCAN_W-1:0] scan_r;
  logic [LEN_W-1:0]  len_r;
  logic [31:0] acc_high_r, acc_low_r;
  logic [31:0] trade_r;

  logic        out_valid_r;
  logic [1:0]  out_action_r;
  logic [22:0] out_qty_r;
  logic [31:0] out_ch_high_r, out_ch_low_r, out_total_r;
  logic        out_ready_flag_r;

  logic [31:0] head_high, head_low;
  cbs_pkg::cell_ctl_t chain_ctl;

  logic              in_fire, out_free, finish_go;
  logic              match_nxt, hist_ok_nxt;
  logic [HELD_W-1:0] held_nxt;
  logic [LEN_W-1:0]  len_nxt;
  logic [1:0]        action_nxt;
  logic [22:0]       qty_nxt;
  logic [31:0]       trade_nxt;
  logic              pos_zero, pos_neg;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign finish_go = (state_r == ST_FINISH) && out_free;

  assign match_nxt = (in_bar_symbol == symbol_id_r);
  assign held_nxt  = (held_r < HELD_MAX) ? held_r + HELD_W'(1) : held_r;
  assign len_nxt   = cbs_pkg::eff_len(lookback_r);
  assign hist_ok_nxt = match_nxt && (held_nxt >= HELD_W'(len_nxt) + HELD_W'(1));

  assign chain_ctl.shift  = finish_go && match_r;
  assign chain_ctl.rotate = (state_r == ST_SCAN);

  cbs_chain u_chain (
    .clk       (clk),
    .ctl       (chain_ctl),
    .new_high  (bar_high_r),
    .new_low   (bar_low_r),
    .head_high (head_high),
    .head_low  (head_low)
  );

  assign pos_zero = (pos_r == 24'd0);
  assign pos_neg  = pos_r[23];

  always_comb begin
    action_nxt = cbs_pkg::ACT_NONE;
    qty_nxt    = 23'd0;
    if (hist_ok_r) begin
      if ((bar_close_r > acc_high_r) && pos_zero) begin
        action_nxt = cbs_pkg::ACT_BUY;
        qty_nxt    = 23'(entry_qty_r);
      end else if ((bar_close_r < acc_low_r) && !pos_neg && !pos_zero) begin
        action_nxt = cbs_pkg::ACT_SELL;
        qty_nxt    = pos_r[22:0];
      end
    end
    trade_nxt = trade_r;
    if ((action_nxt != cbs_pkg::ACT_NONE) && (trade_r != 32'hFFFF_FFFF)) begin
      trade_nxt = trade_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      symbol_id_r <= 16'd0;
      lookback_r  <= cbs_pkg::LOOKBACK_RST;
      entry_qty_r <= cbs_pkg::ENTRY_QTY_RST;
      held_r      <= '0;
      trade_r     <= 32'd0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cbs_pkg::CFG_SYMBOL_ID: symbol_id_r <= cfg_wdata;
          cbs_pkg::CFG_LOOKBACK:  lookback_r  <= cfg_wdata[6:0];
          cbs_pkg::CFG_ENTRY_QTY: entry_qty_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            bar_high_r  <= in_bar_high;
            bar_low_r   <= in_bar_low;
            bar_close_r <= in_bar_close;
            pos_r       <= in_position_qty;
            match_r     <= match_nxt;
            hist_ok_r   <= hist_ok_nxt;
            len_r       <= len_nxt;
            acc_high_r  <= 32'd0;
            acc_low_r   <= 32'hFFFF_FFFF;
            scan_r      <= '0;
            if (match_nxt) begin
              held_r <= held_nxt;
            end
            state_r <= hist_ok_nxt ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          // fold only the newest len words; the rest just pass by to restore order
          if (LEN_W'(scan_r) < len_r) begin
            if (head_high > acc_high_r) acc_high_r <= head_high;
            if (head_low < acc_low_r)   acc_low_r  <= head_low;
          end
          scan_r <= scan_r + SCAN_W'(1);
          if (scan_r == SCAN_LAST) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_action_r     <= action_nxt;
            out_qty_r        <= qty_nxt;
            out_ch_high_r    <= hist_ok_r ? acc_high_r : 32'd0;
            out_ch_low_r     <= hist_ok_r ? acc_low_r  : 32'd0;
            out_ready_flag_r <= hist_ok_r;
            out_total_r      <= trade_nxt;
            trade_r          <= trade_nxt;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_order_qty     = out_qty_r;
  assign out_channel_high  = out_ch_high_r;
  assign out_channel_low   = out_ch_low_r;
  assign out_history_ready = out_ready_flag_r;
  assign out_trade_total   = out_total_r;

endmodule
`default_nettype wire

/* rtl/cbs_cell.sv */
// One history cell: holds the high and low of one past bar.
// Depends on cbs_pkg for the control struct.
`default_nettype none
module cbs_cell (
  input  wire logic             clk,
  input  wire cbs_pkg::cell_ctl_t ctl,
  input  wire logic [31:0]      prev_high,
  input  wire logic [31:0]      prev_low,
  input  wire logic [31:0]      next_high,
  input  wire logic [31:0]      next_low,
  output logic      [31:0]      high,
  output logic      [31:0]      low
);

  logic [31:0] high_r;
  logic [31:0] low_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      high_r <= prev_high;
      low_r  <= prev_low;
    end else if (ctl.rotate) begin
      high_r <= next_high;
      low_r  <= next_low;
    end
  end

  assign high = high_r;
  assign low  = low_r;

endmodule
`default_nettype wire

/* rtl/cbs_chain.sv */
// Row of WINDOW_MAX history cells; cell 0 holds the most recent stored bar.
// Depends on cbs_pkg and cbs_cell.
`default_nettype none
module cbs_chain (
  input  wire logic               clk,
  input  wire cbs_pkg::cell_ctl_t ctl,
  input  wire logic [31:0]        new_high,
  input  wire logic [31:0]        new_low,
  output logic      [31:0]        head_high,
  output logic      [31:0]        head_low
);

  localparam int N = cbs_pkg::WINDOW_MAX;

  logic [31:0] cell_high [N];
  logic [31:0] cell_low  [N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [31:0] ph, pl, nh, nl;
    if (k == 0) begin : g_head
      assign ph = new_high;
      assign pl = new_low;
    end else begin : g_body
      assign ph = cell_high[k-1];
      assign pl = cell_low[k-1];
    end
    // the head wraps to the tail while rotating
    if (k == N - 1) begin : g_tail
      assign nh = cell_high[0];
      assign nl = cell_low[0];
    end else begin : g_mid
      assign nh = cell_high[k+1];
      assign nl = cell_low[k+1];
    end
    cbs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_high (ph),
      .prev_low  (pl),
      .next_high (nh),
      .next_low  (nl),
      .high      (cell_high[k]),
      .low       (cell_low[k])
    );
  end

  assign head_high = cell_high[0];
  assign head_low  = cell_low[0];

endmodule
`default_nettype wire

/* rtl/cbs_checker.sv */
// Port-level checks for channel_breakout_signal, attached by bind.
// Depends on cbs_pkg for the action codes.
`default_nettype none
module cbs_port_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_action,
  input wire logic [22:0] out_order_qty,
  input wire logic [31:0] out_channel_high,
  input wire logic [31:0] out_channel_low,
  input wire logic        out_history_ready,
  input wire logic [31:0] out_trade_total
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // no order without a formed channel, and no channel values then
  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_history_ready |->
      out_action == cbs_pkg::ACT_NONE && out_order_qty == 23'd0 &&
      out_channel_high == 32'd0 && out_channel_low == 32'd0)
    else $error("order or channel shown without history");

  a_none_qty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == cbs_pkg::ACT_NONE |-> out_order_qty == 23'd0)
    else $error("quantity without an order");

  a_sell_qty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == cbs_pkg::ACT_SELL |-> out_order_qty != 23'd0)
    else $error("sell of an empty position");

  a_order_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == cbs_pkg::ACT_BUY || out_action == cbs_pkg::ACT_SELL)
      |-> out_trade_total != 32'd0)
    else $error("order emitted but trade total is zero");

endmodule

bind channel_breakout_signal cbs_port_props u_cbs_port_props (.*);
`default_nettype wire
